/* rtl/tdt_pkg.sv */
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants of the task delay timer bank
// Sizes of the task bank, operation codes and the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdt_pkg;

	localparam int NUM_TASKS = 8;
	localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int MASK_BITS = 8;
	localparam int PAD_W     = (NUM_TASKS > MASK_BITS) ? NUM_TASKS : MASK_BITS;
	localparam int CNT_W     = 16;
	localparam int TASK_W    = 3;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_DELAY = 1'b1;

	typedef struct packed {
		logic [MASK_BITS-1:0] woken;
		logic [MASK_BITS-1:0] blocked;
	} result_t;

endpackage

/* rtl/tdt_ram.sv */
// ----------------------------------------------------------------------------
// tdt_ram: single-port-write, single-port-read synchronous RAM
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdt_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 16,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/tdt_ctrl.sv */
// ----------------------------------------------------------------------------
// tdt_ctrl: request handling and tick sweep over the counter memory
// Holds the blocked flags, walks the counters one task per cycle on a
// tick and hands a finished result word to the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdt_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              op,
	input  logic [tdt_pkg::TASK_W-1:0]        task_id,
	input  logic [tdt_pkg::CNT_W-1:0]         tick_count,
	output logic                              res_valid,
	input  logic                              res_ready,
	output tdt_pkg::result_t                  res,
	output logic                              mem_wr_en,
	output logic [tdt_pkg::IDX_W-1:0]         mem_wr_addr,
	output logic [tdt_pkg::CNT_W-1:0]         mem_wr_data,
	output logic [tdt_pkg::IDX_W-1:0]         mem_rd_addr,
	input  logic [tdt_pkg::CNT_W-1:0]         mem_rd_data
);

	import tdt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [NUM_TASKS-1:0] blk_q;
	logic [PAD_W-1:0]     woken_q;
	logic [PAD_W-1:0]     blk_pad;
	logic                 accept;
	logic                 req_ok;
	logic                 dec_en;
	logic [CNT_W-1:0]     dec_val;

	assign accept  = req_valid && !req_stall;
	assign req_ok  = (tick_count != '0) && (32'(task_id) < NUM_TASKS);
	assign dec_en  = (state_q == ST_SWEEP) && blk_q[idx_q] && (mem_rd_data != '0);
	assign dec_val = mem_rd_data - CNT_W'(1);

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_FINISH);
	assign blk_pad   = PAD_W'(blk_q);
	assign res.woken   = woken_q[MASK_BITS-1:0];
	assign res.blocked = blk_pad[MASK_BITS-1:0];

	// The read for the next task is issued while the current one is written
	// back, so during a sweep reads and writes never touch the same entry in one cycle.
	always_comb begin
		mem_rd_addr = (state_q == ST_SWEEP) ? idx_q + IDX_W'(1) : '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = dec_val;
		if (state_q == ST_IDLE) begin
			mem_wr_en   = accept && (op == OP_DELAY) && req_ok;
			mem_wr_addr = IDX_W'(task_id);
			mem_wr_data = tick_count;
		end else if (dec_en) begin
			mem_wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			blk_q   <= '0;
			woken_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						woken_q <= '0;
						idx_q   <= '0;
						if (op == OP_DELAY) begin
							if (req_ok) begin
								blk_q[IDX_W'(task_id)] <= 1'b1;
							end
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (dec_en && (dec_val == '0)) begin
						blk_q[idx_q]   <= 1'b0;
						woken_q[idx_q] <= 1'b1;
					end
					if (idx_q == IDX_W'(NUM_TASKS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/task_delay_timer_bank.sv */
// ----------------------------------------------------------------------------
// task_delay_timer_bank: per-task delay counters with tick-driven release
// A delay request passes from IDLE through FINISH before the next acceptance.
// A tick sweeps the counter memory one task per cycle through its single
// read and write port, then passes through FINISH before the next one.
// The result word is captured in an output register when it is handed over.
// Reset clears all blocked flags and the control state at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_delay_timer_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           op,
	input  logic [tdt_pkg::TASK_W-1:0]     task_id,
	input  logic [tdt_pkg::CNT_W-1:0]      tick_count,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [tdt_pkg::MASK_BITS-1:0]  woken_mask,
	output logic [tdt_pkg::MASK_BITS-1:0]  blocked_mask
);

	import tdt_pkg::*;

	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	logic [CNT_W-1:0] mem_wr_data;
	logic [IDX_W-1:0] mem_rd_addr;
	logic [CNT_W-1:0] mem_rd_data;
	logic             out_valid_q;
	result_t          out_q;

	tdt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.task_id     (task_id),
		.tick_count  (tick_count),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	tdt_ram #(
		.DEPTH (NUM_TASKS),
		.WIDTH (CNT_W),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// The output register frees as the waiting word is taken.
	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign woken_mask   = out_q.woken;
	assign blocked_mask = out_q.blocked;

`ifndef ASSERT_OFF
	a_woken_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((woken_mask & blocked_mask) == '0))
		else $error("woken task still shown as blocked");

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request side open in the cycle after an accepted word");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> (rsp_valid && rsp_stall))
		else $error("result held back while the output register is free");
`endif

endmodule
